[rtl/core/sps_pkg.sv]
// sps_pkg: shared types, codes, phase table and step arithmetic helpers
// for the six-axis stepper phase sequencer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sps_pkg;

  localparam int NUM_MOTORS_DEF = 6;
  localparam int POS_W          = 16;
  localparam int IDX_W          = 3;
  localparam int APB_DW         = 32;
  localparam int APB_AW         = 3;

  localparam logic [IDX_W-1:0] ALL_INDEX = 3'd6;

  // command codes
  localparam logic [1:0] CMD_STEP = 2'd0;
  localparam logic [1:0] CMD_STOP = 2'd1;
  localparam logic [1:0] CMD_HOME = 2'd2;

  // remote step mode codes
  localparam logic [1:0] MODE_LOCAL = 2'd0;
  localparam logic [1:0] MODE_HALF  = 2'd1;
  localparam logic [1:0] MODE_FULL  = 2'd2;

  localparam logic [1:0] SIZE_FULL = 2'd2;

  // register indexes (paddr[2])
  localparam logic REG_REMOTE_MODE = 1'b0;
  localparam logic REG_LOCAL_SIZE  = 1'b1;

  // half-step coil patterns, indexed by position mod 8
  localparam logic [3:0] PHASE_COILS [8] = '{
    4'b0001, 4'b0101, 4'b0100, 4'b0110,
    4'b0010, 4'b1010, 4'b1000, 4'b1001
  };

  typedef struct packed {
    logic [1:0] remote_mode;
    logic [1:0] local_size;
  } cfg_t;

  typedef struct packed {
    logic              fix;   // 1: add -dir (full-step pullback), 0: add dir*size
    logic signed [1:0] dir;
    logic [1:0]        size;
  } alu_ctl_t;

  // dir * size, sign-extended to position width
  function automatic logic [POS_W-1:0] step_delta(logic signed [1:0] dir, logic [1:0] size);
    logic signed [4:0] prod;
    prod = $signed({{3{dir[1]}}, dir}) * $signed({3'b000, size});
    return {{(POS_W-5){prod[4]}}, prod};
  endfunction

endpackage

`default_nettype wire

[rtl/core/sps_chan_if.sv]
// sps_chan_if: valid/ready channel interfaces for command words and
// coil-write result words. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface sps_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [2:0]        motor_index;
  logic signed [1:0] direction;

  modport source (output valid, cmd, motor_index, direction, input ready);
  modport sink   (input valid, cmd, motor_index, direction, output ready);
endinterface

interface sps_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         reg_addr;
  logic [3:0]         coil_bits;
  logic signed [15:0] position;
  logic               error;
  logic               last;

  modport source (output valid, reg_addr, coil_bits, position, error, last, input ready);
  modport sink   (input valid, reg_addr, coil_bits, position, error, last, output ready);
endinterface

`default_nettype wire

[rtl/core/sps_cfg.sv]
// sps_cfg: APB-style register file holding the step mode settings.
// Depends on sps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sps_cfg
  import sps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [1:0] remote_mode_r;
  logic [1:0] local_size_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remote_mode_r <= MODE_FULL;
      local_size_r  <= SIZE_FULL;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_REMOTE_MODE: remote_mode_r <= pwdata[1:0];
        REG_LOCAL_SIZE:  local_size_r  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_REMOTE_MODE: prdata = {{(APB_DW-2){1'b0}}, remote_mode_r};
      REG_LOCAL_SIZE:  prdata = {{(APB_DW-2){1'b0}}, local_size_r};
      default:         prdata = '0;
    endcase
  end

  assign cfg = '{remote_mode: remote_mode_r, local_size: local_size_r};

endmodule

`default_nettype wire

[rtl/core/sps_alu.sv]
// sps_alu: shared 16-bit position adder; adds either dir*size or -dir.
// Depends on sps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sps_alu
  import sps_pkg::*;
(
  input  wire logic [POS_W-1:0] acc,
  input  wire alu_ctl_t         ctl,
  output logic      [POS_W-1:0] sum
);

  logic [POS_W-1:0] dir_ext;
  logic [POS_W-1:0] operand;

  assign dir_ext = {{(POS_W-2){ctl.dir[1]}}, ctl.dir};
  assign operand = ctl.fix ? (~dir_ext + POS_W'(1)) : step_delta(ctl.dir, ctl.size);
  assign sum     = acc + operand;

endmodule

`default_nettype wire

[rtl/core/sps_seq.sv]
// sps_seq: command sequencer, motor position registers and result register.
// Depends on sps_pkg, sps_chan_if and sps_alu.
`timescale 1ns / 1ps
`default_nettype none

module sps_seq
  import sps_pkg::*;
#(
  parameter int NUM_MOTORS = NUM_MOTORS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  sps_in_if.sink     in_ch,
  sps_out_if.source  out_ch
);

  localparam int MOT_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam logic [IDX_W-1:0] NUM_M  = IDX_W'(NUM_MOTORS);
  localparam logic [IDX_W-1:0] LAST_M = IDX_W'(NUM_MOTORS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  localparam logic [1:0] OP_STEP = 2'd0;
  localparam logic [1:0] OP_STOP = 2'd1;
  localparam logic [1:0] OP_HOME = 2'd2;
  localparam logic [1:0] OP_ERR  = 2'd3;

  logic [2:0]        state_r;
  logic [1:0]        op_r;
  logic              all_r;
  logic [IDX_W-1:0]  motor_r;
  logic signed [1:0] dir_r;
  logic [POS_W-1:0]  acc_r;
  logic [POS_W-1:0]  pos_r [NUM_MOTORS];

  logic              out_valid_r;
  logic [IDX_W-1:0]  out_addr_r;
  logic [3:0]        out_coils_r;
  logic [POS_W-1:0]  out_pos_r;
  logic              out_err_r;
  logic              out_last_r;

  logic             arith;
  logic             full;
  logic [1:0]       size;
  logic             can_load;
  logic             is_last;
  alu_ctl_t         alu_ctl;
  logic [POS_W-1:0] alu_sum;

  assign arith = (op_r == OP_STEP) || (op_r == OP_HOME);

  always_comb begin
    unique case (cfg.remote_mode) inside
      MODE_LOCAL:           size = cfg.local_size;
      MODE_HALF, MODE_FULL: size = cfg.remote_mode;
      default:              size = 2'd0;
    endcase
  end

  assign full = (cfg.remote_mode == MODE_FULL) ||
                ((cfg.remote_mode == MODE_LOCAL) && (cfg.local_size == SIZE_FULL));

  assign alu_ctl.fix  = (state_r == S_FIX);
  assign alu_ctl.dir  = dir_r;
  assign alu_ctl.size = size;

  sps_alu u_alu (
    .acc (acc_r),
    .ctl (alu_ctl),
    .sum (alu_sum)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign can_load    = !out_valid_r || out_ch.ready;
  assign is_last     = !all_r || (motor_r == LAST_M);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_STEP;
      all_r   <= 1'b0;
      motor_r <= '0;
      dir_r   <= '0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        pos_r[i] <= POS_W'(1);
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            dir_r   <= in_ch.direction;
            motor_r <= in_ch.motor_index;
            all_r   <= 1'b0;
            state_r <= S_LOAD;
            unique case (in_ch.cmd)
              CMD_STEP: begin
                op_r <= (in_ch.motor_index < NUM_M) ? OP_STEP : OP_ERR;
              end
              CMD_STOP: begin
                if (in_ch.motor_index < NUM_M) begin
                  op_r <= OP_STOP;
                end else if (in_ch.motor_index == ALL_INDEX) begin
                  op_r    <= OP_STOP;
                  all_r   <= 1'b1;
                  motor_r <= '0;
                end else begin
                  op_r <= OP_ERR;
                end
              end
              CMD_HOME: begin
                op_r    <= OP_HOME;
                all_r   <= 1'b1;
                motor_r <= '0;
                dir_r   <= 2'sd1;
              end
              default: state_r <= S_IDLE;  // unused code: drop the word
            endcase
          end
        end
        S_LOAD: begin
          unique case (op_r) inside
            OP_HOME:          acc_r <= '0;
            OP_STEP, OP_STOP: acc_r <= pos_r[motor_r[MOT_W-1:0]];
            default:          acc_r <= '0;
          endcase
          state_r <= arith ? S_ADD : S_EMIT;
        end
        S_ADD: begin
          acc_r   <= alu_sum;
          state_r <= S_FIX;
        end
        S_FIX: begin
          if (full && !acc_r[0]) begin
            acc_r <= alu_sum;
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (can_load) begin
            if (arith) begin
              pos_r[motor_r[MOT_W-1:0]] <= acc_r;
            end
            if (is_last) begin
              state_r <= S_IDLE;
            end else begin
              motor_r <= motor_r + IDX_W'(1);
              state_r <= S_LOAD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && can_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && can_load) begin
      out_addr_r  <= (op_r == OP_ERR) ? '0 : motor_r;
      out_coils_r <= arith ? PHASE_COILS[acc_r[2:0]] : 4'b0000;
      out_pos_r   <= acc_r;
      out_err_r   <= (op_r == OP_ERR);
      out_last_r  <= is_last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.reg_addr  = out_addr_r;
  assign out_ch.coil_bits = out_coils_r;
  assign out_ch.position  = out_pos_r;
  assign out_ch.error     = out_err_r;
  assign out_ch.last      = out_last_r;

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |->
      (out_addr_r == '0 && out_coils_r == 4'b0000 && out_pos_r == '0 && out_last_r))
    else $error("error word carries nonzero fields");

  a_motor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && op_r != OP_ERR) |-> (motor_r < NUM_M))
    else $error("motor index out of range while busy");

  a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EMIT))
    else $error("result loaded outside emit");

  a_home_odd_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && op_r == OP_HOME && full) |-> acc_r[0])
    else $error("home in full-step left an even position");

endmodule

`default_nettype wire

[rtl/core/six_axis_stepper_phase_sequencer_top.sv]
// Top level of the six-axis stepper phase sequencer.
// Depends on sps_pkg, sps_chan_if, sps_cfg and sps_seq.
//
// Usage:
//   in_ch  : command word (cmd, motor_index, direction), valid/ready.
//   out_ch : coil-write word (reg_addr, coil_bits, position, error, last).
//   cfg_*  : APB-style port; reg 0 at 0x0 remote step mode, reg 1 at 0x4
//            local step size. pready is tied high. Write only while idle.
// Sequencing:
//   A step runs from accept to result load through the load, add, full-step
//   fix and emit states, all through one shared 16-bit adder. Stop and error
//   words run through load and emit only. Home runs load, add, fix and emit
//   for each motor in turn; stop-all runs load and emit per motor.
//   in_ch.ready is high only while the sequencer is idle, so one command is worked
//   at a time. Results sit in a one-word output register; a stalled receiver holds
//   the sequencer in its emit step, and the next command is accepted from the
//   cycle after the final word of the current one is loaded, even while it waits.
// Reset (rst_n, sync, active low): all positions go to 1, remote mode and
//   local size to 2 (full step), no output word valid.
`timescale 1ns / 1ps
`default_nettype none

module six_axis_stepper_phase_sequencer_top
  import sps_pkg::*;
#(
  parameter int NUM_MOTORS = NUM_MOTORS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  sps_in_if.sink                 in_ch,
  sps_out_if.source              out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [APB_AW-1:0] cfg_paddr,
  input  wire logic [APB_DW-1:0] cfg_pwdata,
  output logic      [APB_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t cfg;

  // mode registers
  sps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // sequencer, positions, shared adder and result register
  sps_seq #(
    .NUM_MOTORS (NUM_MOTORS)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

[test/tb_top.sv]
// tb_top: self-checking testbench for six_axis_stepper_phase_sequencer_top.
// Needs sps_pkg, the sps_in_if/sps_out_if channel interfaces and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import sps_pkg::*;

  localparam int NMOT = NUM_MOTORS_DEF;

  // remote mode pattern 3: coils are rewritten, position holds
  localparam logic [1:0] MODE_HOLD = 2'd3;
  // unused command pattern, block drops it without a word
  localparam logic [1:0] CMD_NONE = 2'd3;

  // a home sweep is the longest internal job, so idle a bit past it
  localparam int SETTLE_CYCLES   = 32;
  localparam int ITEMS_PER_PHASE = 45;
  localparam int WRAP_STEPS      = 8;
  localparam longint LIMIT_NS    = 4_000_000;

  // half-step table: row k gives coil k per phase (position mod 8), phase 0 first
  localparam bit [0:7] COIL_ROWS [4] = '{
    8'b11000001, 8'b00011100, 8'b01110000, 8'b00000111
  };

  // (remote mode, local size) pairs walked by the random phases
  localparam logic [1:0] PHASE_MODE [8] = '{
    MODE_HALF, MODE_LOCAL, MODE_LOCAL, MODE_LOCAL,
    MODE_LOCAL, MODE_HOLD, MODE_FULL, MODE_HOLD
  };
  localparam logic [1:0] PHASE_SIZE [8] = '{
    2'd1, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1, 2'd0
  };

  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_SPARSE} sink_style_t;

  typedef struct packed {
    logic [2:0]         reg_addr;
    logic [3:0]         coil_bits;
    logic signed [15:0] position;
    logic               error;
    logic               last;
  } coil_word_t;

  logic clk = 1'b0;
  logic rst_n;

  always #2 clk = ~clk;

  sps_in_if  in_if ();
  sps_out_if out_if ();

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  wire  [APB_DW-1:0] cfg_prdata;
  wire               cfg_pready;

  six_axis_stepper_phase_sequencer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // shadow of the block's state, advanced at every accepted command word
  logic [15:0] shadow_pos [NMOT];
  logic [1:0]  remote_mode;
  logic [1:0]  local_size;

  coil_word_t coil_writes_due [$];
  coil_word_t due_word;
  int         fail_count = 0;

  // sender pacing
  int burst_left    = 0;
  bit steady_sender = 1'b0;

  // ---------------------------------------------------------------------------
  // Shadow model of the sequencer
  // ---------------------------------------------------------------------------

  function automatic logic [3:0] coils_of(logic [15:0] pos);
    logic [3:0] bits;
    bits = '0;
    for (int k = 0; k < 4; k++) bits[k] = COIL_ROWS[k][pos[2:0]];
    return bits;
  endfunction

  // one step by d (16-bit two's complement), with the full-step odd-phase pullback
  function automatic logic [15:0] next_position(logic [15:0] pos, logic [15:0] d);
    logic [15:0] n;
    logic        full;
    n = pos;
    case (remote_mode)
      MODE_LOCAL:           n = pos + d * {14'b0, local_size};
      MODE_HALF, MODE_FULL: n = pos + d * {14'b0, remote_mode};
      default: ;  // hold mode: no move
    endcase
    full = (remote_mode == MODE_FULL) ||
           (remote_mode == MODE_LOCAL && local_size == SIZE_FULL);
    if (full && !n[0]) n = n - d;
    return n;
  endfunction

  function automatic coil_word_t make_word(logic [2:0] addr, logic [3:0] coils,
                                           logic [15:0] pos, logic err, logic fin);
    coil_word_t w;
    w.reg_addr  = addr;
    w.coil_bits = coils;
    w.position  = pos;
    w.error     = err;
    w.last      = fin;
    return w;
  endfunction

  // queue up the coil words one command word should produce
  task automatic predict_command(logic [1:0] cmd, logic [2:0] idx, logic [1:0] dir);
    logic [15:0] d;
    d = {{14{dir[1]}}, dir};
    case (cmd)
      CMD_STEP: begin
        if (idx < NMOT) begin
          shadow_pos[idx] = next_position(shadow_pos[idx], d);
          coil_writes_due.push_back(make_word(idx, coils_of(shadow_pos[idx]),
                                              shadow_pos[idx], 1'b0, 1'b1));
        end else begin
          coil_writes_due.push_back(make_word(3'd0, 4'd0, 16'd0, 1'b1, 1'b1));
        end
      end
      CMD_STOP: begin
        if (idx < NMOT) begin
          coil_writes_due.push_back(make_word(idx, 4'd0, shadow_pos[idx], 1'b0, 1'b1));
        end else if (idx == ALL_INDEX) begin
          for (int i = 0; i < NMOT; i++)
            coil_writes_due.push_back(make_word(i[2:0], 4'd0, shadow_pos[i], 1'b0,
                                                i == NMOT - 1));
        end else begin
          coil_writes_due.push_back(make_word(3'd0, 4'd0, 16'd0, 1'b1, 1'b1));
        end
      end
      CMD_HOME: begin
        for (int i = 0; i < NMOT; i++) begin
          shadow_pos[i] = next_position(16'd0, 16'd1);
          coil_writes_due.push_back(make_word(i[2:0], coils_of(shadow_pos[i]),
                                              shadow_pos[i], 1'b0, i == NMOT - 1));
        end
      end
      default: ;  // unused code: no word, no state change
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checker
  // ---------------------------------------------------------------------------

  // receiver picks a new stall style whenever its hold count runs out; open stretches included
  initial begin : result_sink
    int          hold_left;
    int          tick;
    sink_style_t style;
    out_if.ready = 1'b0;
    hold_left    = 0;
    tick         = 0;
    style        = SINK_OPEN;
    forever begin
      @(negedge clk);
      if (hold_left == 0) begin
        style     = sink_style_t'($urandom_range(0, 3));
        hold_left = $urandom_range(16, 96);
      end
      hold_left--;
      tick++;
      case (style)
        SINK_OPEN:     out_if.ready <= 1'b1;
        SINK_RANDOM:   out_if.ready <= 1'($urandom_range(0, 1));
        SINK_PERIODIC: out_if.ready <= (tick % 4 != 0);
        default:       out_if.ready <= (tick % 6 == 0);
      endcase
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // every accepted coil word is matched against the oldest one due
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (coil_writes_due.size() == 0) begin
        $error("unexpected coil word: reg_addr %0d coil_bits %0h position %0d",
               out_if.reg_addr, out_if.coil_bits, out_if.position);
        fail_count++;
      end else begin
        due_word = coil_writes_due.pop_front();
        check_field("reg_addr",  int'(due_word.reg_addr),  int'(out_if.reg_addr));
        check_field("coil_bits", int'(due_word.coil_bits), int'(out_if.coil_bits));
        check_field("position",  int'(due_word.position),  int'(out_if.position));
        check_field("error",     int'(due_word.error),     int'(out_if.error));
        check_field("last",      int'(due_word.last),      int'(out_if.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command side and config port
  // ---------------------------------------------------------------------------

  // sends one command word; sender idles between bursts unless steady_sender.
  // valid stays high from word to word inside a burst.
  task automatic send_cmd(logic [1:0] cmd, logic [2:0] idx, logic [1:0] dir);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = steady_sender ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_if.valid       <= 1'b1;
    in_if.cmd         <= cmd;
    in_if.motor_index <= idx;
    in_if.direction   <= dir;
    do @(posedge clk); while (!in_if.ready);
    predict_command(cmd, idx, dir);
  endtask

  // block idle: input low, all words out, plus room for a trailing unused command
  task automatic quiesce();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (coil_writes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // two-phase write: setup, then access until pready
  task automatic cfg_write(logic reg_sel, logic [1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= {{(APB_DW-2){1'b0}}, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (reg_sel == REG_REMOTE_MODE) remote_mode = value;
    else local_size = value;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic program_step_config(logic [1:0] mode, logic [1:0] size);
    quiesce();
    cfg_write(REG_REMOTE_MODE, mode);
    cfg_write(REG_LOCAL_SIZE, size);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset state, each command kind, bad indexes, dir 0 and -2, unused code
  task automatic test_directed_commands();
    send_cmd(CMD_STOP, ALL_INDEX, 2'b00);  // reset positions all 1
    send_cmd(CMD_STEP, 3'd0, 2'b01);
    send_cmd(CMD_STEP, 3'd0, 2'b11);
    send_cmd(CMD_STEP, 3'd1, 2'b00);       // no direction
    send_cmd(CMD_STEP, 3'd2, 2'b10);       // pattern 2 reads as -2
    send_cmd(CMD_STEP, 3'd3, 2'b01);
    send_cmd(CMD_STEP, 3'd4, 2'b01);
    send_cmd(CMD_STEP, 3'd5, 2'b11);
    send_cmd(CMD_STEP, 3'd6, 2'b01);       // step to the all index: error
    send_cmd(CMD_STEP, 3'd7, 2'b11);       // out of range: error
    send_cmd(CMD_STOP, 3'd3, 2'b00);
    send_cmd(CMD_STOP, 3'd5, 2'b01);
    send_cmd(CMD_STOP, 3'd7, 2'b10);       // stop to 7: error
    send_cmd(CMD_NONE, 3'd7, 2'b10);       // dropped
    send_cmd(CMD_HOME, 3'd0, 2'b00);       // even 2 pulled back to 1 per motor
    send_cmd(CMD_STOP, ALL_INDEX, 2'b11);
    send_cmd(CMD_STEP, 3'd0, 2'b01);
    send_cmd(CMD_STEP, 3'd5, 2'b10);
    send_cmd(CMD_STEP, 3'd4, 2'b01);
    send_cmd(CMD_HOME, 3'd7, 2'b11);       // home ignores index and direction
  endtask

  // walk motor 0 down by 6 per step through zero, so the sum borrows out of 16 bits
  task automatic test_position_wrap();
    program_step_config(MODE_LOCAL, 2'd3);
    steady_sender = 1'b1;
    repeat (WRAP_STEPS) send_cmd(CMD_STEP, 3'd0, 2'b10);
    send_cmd(CMD_STOP, 3'd0, 2'b00);
    steady_sender = 1'b0;
  endtask

  // mixed traffic under each config pair; mostly valid steps, some noise
  task automatic test_random_traffic();
    int         counted;
    int         r;
    logic [1:0] cmd;
    logic [1:0] dir;
    logic [2:0] idx;
    for (int ph = 0; ph < 8; ph++) begin
      program_step_config(PHASE_MODE[ph], PHASE_SIZE[ph]);
      steady_sender = (ph % 3 == 2);
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        r   = $urandom_range(0, 99);
        dir = 2'($urandom_range(0, 3));
        idx = 3'($urandom_range(0, NMOT - 1));
        if (r < 62) begin
          cmd = CMD_STEP;
        end else if (r < 74) begin
          cmd = CMD_STOP;
        end else if (r < 80) begin
          cmd = CMD_STOP;
          idx = ALL_INDEX;
        end else if (r < 86) begin
          cmd = CMD_HOME;
          idx = 3'($urandom_range(0, 7));
        end else if (r < 94) begin
          cmd = $urandom_range(0, 1) ? CMD_STEP : CMD_STOP;
          idx = 3'($urandom_range(6, 7));
          if (cmd == CMD_STOP) idx = 3'd7;
        end else begin
          cmd = CMD_NONE;
          idx = 3'($urandom_range(0, 7));
        end
        send_cmd(cmd, idx, dir);
        if (cmd != CMD_NONE) counted++;
      end
    end
    steady_sender = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Run sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.cmd         = CMD_STEP;
    in_if.motor_index = 3'd0;
    in_if.direction   = 2'b00;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;

    // reset values of the shadow state
    for (int i = 0; i < NMOT; i++) shadow_pos[i] = 16'd1;
    remote_mode = MODE_FULL;
    local_size  = SIZE_FULL;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_commands();
    test_position_wrap();
    test_random_traffic();

    quiesce();
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #(LIMIT_NS);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

[sim.f]
rtl/core/sps_pkg.sv
rtl/core/sps_chan_if.sv
rtl/core/sps_cfg.sv
rtl/core/sps_alu.sv
rtl/core/sps_seq.sv
rtl/core/six_axis_stepper_phase_sequencer_top.sv
test/tb_top.sv
